>>> rtl/hstep_pkg.sv
package hstep_pkg;

  localparam int unsigned CountW = 16;
  localparam int unsigned CoilW  = 4;
  localparam int unsigned PhaseW = 3;

  localparam logic REQ_MOVE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic [CoilW-1:0]  SETUP_COILS   = 4'h8;
  localparam logic [PhaseW-1:0] PHASE_FWD_START = 3'd0;
  localparam logic [PhaseW-1:0] PHASE_REV_START = 3'd7;

  typedef struct packed {
    logic              req_type;
    logic              direction;
    logic [CountW-1:0] step_count;
    logic [CountW-1:0] hold_ms;
  } in_item_t;

  typedef struct packed {
    logic [CoilW-1:0] coils;
    logic             enable;
    logic             busy_res;
    logic             done_res;
  } out_item_t;

  // coil flipped when leaving a given phase
  function automatic logic [CoilW-1:0] toggle_mask(input logic [PhaseW-1:0] ph);
    logic [CoilW-1:0] m;
    case (ph)
      3'd0: m = 4'h2;
      3'd1: m = 4'h8;
      3'd2: m = 4'h4;
      3'd3: m = 4'h2;
      3'd4: m = 4'h1;
      3'd5: m = 4'h4;
      3'd6: m = 4'h8;
      3'd7: m = 4'h1;
      default: m = 4'h0;
    endcase
    return m;
  endfunction

endpackage

>>> rtl/hstep_ifs.sv
interface hstep_in_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic                          direction;
  logic [hstep_pkg::CountW-1:0]  step_count;
  logic [hstep_pkg::CountW-1:0]  hold_ms;

  modport source (output valid, req_type, direction, step_count, hold_ms, input ready);
  modport sink   (input valid, req_type, direction, step_count, hold_ms, output ready);
endinterface

interface hstep_out_if;
  logic                         valid;
  logic                         ready;
  logic [hstep_pkg::CoilW-1:0]  coils;
  logic                         enable;
  logic                         busy_res;
  logic                         done_res;

  modport source (output valid, coils, enable, busy_res, done_res, input ready);
  modport sink   (input valid, coils, enable, busy_res, done_res, output ready);
endinterface

>>> rtl/hstep_in_stage.sv
module hstep_in_stage (
  input  logic                clk,
  input  logic                rst,
  hstep_in_if.sink            cmd,
  input  logic                down_ready,
  output logic                valid,
  output hstep_pkg::in_item_t item
);

  assign cmd.ready = !valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.ready) begin
      valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      item.req_type   <= cmd.req_type;
      item.direction  <= cmd.direction;
      item.step_count <= cmd.step_count;
      item.hold_ms    <= cmd.hold_ms;
    end
  end

endmodule

>>> rtl/hstep_core.sv
module hstep_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  hstep_pkg::in_item_t  item,
  output hstep_pkg::out_item_t result
);

  logic [hstep_pkg::CoilW-1:0]  coil_pattern, coil_pattern_next;
  logic [hstep_pkg::PhaseW-1:0] phase, phase_next;
  logic                         setup_pending, setup_pending_next;
  logic [hstep_pkg::CountW-1:0] steps_left, steps_left_next;
  logic [hstep_pkg::CountW-1:0] hold_left, hold_left_next;
  logic [hstep_pkg::CountW-1:0] hold_time, hold_time_next;
  logic                         move_forward, move_forward_next;
  logic                         running, running_next;
  logic                         done;

  always_comb begin
    coil_pattern_next  = coil_pattern;
    phase_next         = phase;
    setup_pending_next = setup_pending;
    steps_left_next    = steps_left;
    hold_left_next     = hold_left;
    hold_time_next     = hold_time;
    move_forward_next  = move_forward;
    running_next       = running;
    done               = 1'b0;

    if (item.req_type == hstep_pkg::REQ_MOVE) begin
      // commands while busy, and zero-length moves, are dropped
      if (!running && item.step_count != '0) begin
        running_next       = 1'b1;
        setup_pending_next = 1'b1;
        steps_left_next    = item.step_count;
        hold_time_next     = item.hold_ms;
        hold_left_next     = '0;
        move_forward_next  = item.direction;
        coil_pattern_next  = '0;
      end
    end else if (running) begin
      if (hold_left > hstep_pkg::CountW'(1)) begin
        hold_left_next = hold_left - hstep_pkg::CountW'(1);
      end else begin
        hold_left_next = '0;
        if (steps_left == '0) begin
          coil_pattern_next  = '0;
          running_next       = 1'b0;
          setup_pending_next = 1'b0;
          done               = 1'b1;
        end else begin
          steps_left_next = steps_left - hstep_pkg::CountW'(1);
          if (setup_pending) begin
            setup_pending_next = 1'b0;
            coil_pattern_next  = hstep_pkg::SETUP_COILS;
            phase_next = move_forward ? hstep_pkg::PHASE_FWD_START
                                      : hstep_pkg::PHASE_REV_START;
          end else begin
            coil_pattern_next = coil_pattern ^ hstep_pkg::toggle_mask(phase);
            phase_next = move_forward ? phase + hstep_pkg::PhaseW'(1)
                                      : phase - hstep_pkg::PhaseW'(1);
            hold_left_next = hold_time;
          end
        end
      end
    end

    result.coils    = coil_pattern_next;
    result.enable   = running_next;
    result.busy_res = running_next;
    result.done_res = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coil_pattern  <= '0;
      phase         <= '0;
      setup_pending <= 1'b0;
      steps_left    <= '0;
      hold_left     <= '0;
      hold_time     <= '0;
      move_forward  <= 1'b0;
      running       <= 1'b0;
    end else if (fire) begin
      coil_pattern  <= coil_pattern_next;
      phase         <= phase_next;
      setup_pending <= setup_pending_next;
      steps_left    <= steps_left_next;
      hold_left     <= hold_left_next;
      hold_time     <= hold_time_next;
      move_forward  <= move_forward_next;
      running       <= running_next;
    end
  end

endmodule

>>> rtl/hstep_out_stage.sv
module hstep_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  output logic                 load_ready,
  input  hstep_pkg::out_item_t item,
  hstep_out_if.source          res
);

  hstep_pkg::out_item_t held;

  assign load_ready = !res.valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (load_ready) begin
      res.valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_ready) begin
      held <= item;
    end
  end

  assign res.coils    = held.coils;
  assign res.enable   = held.enable;
  assign res.busy_res = held.busy_res;
  assign res.done_res = held.done_res;

endmodule

>>> rtl/stepper_half_step_sequencer_top.sv
// Half-step stepper sequencer.
// Channels: cmd takes one beat per request: a move command (req_type 0, with
// direction, step_count, hold_ms) or a millisecond tick (req_type 1).
// res returns exactly one beat per cmd beat, in order: coil lines, enable,
// busy and a done pulse on the tick that ends a move.
// Path: a request is held in the input register, then the sequencer update is
// registered into the result register, which offers it on res.
// Throughput: one request per cycle while res is taken; the sequencer state is
// a handful of registers updated together each time a request fires.
// Reset (rst, synchronous): sequencer idle, its coil and enable state low, both
// pipeline registers empty.
// Stall: while res is not taken the result register holds; the input
// register still fills, and cmd.ready drops once both are occupied.
module stepper_half_step_sequencer_top (
  input  logic        clk,
  input  logic        rst,
  hstep_in_if.sink    cmd,
  hstep_out_if.source res
);

  logic                  s1_valid;
  hstep_pkg::in_item_t   s1_item;
  logic                  out_ready;
  logic                  fire;
  hstep_pkg::out_item_t  result;

  assign fire = s1_valid && out_ready;

  hstep_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .down_ready (out_ready),
    .valid      (s1_valid),
    .item       (s1_item)
  );

  hstep_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (s1_item),
    .result (result)
  );

  hstep_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (fire),
    .load_ready (out_ready),
    .item       (result),
    .res        (res)
  );

endmodule

>>> rtl/hstep_checker.sv
module hstep_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic [hstep_pkg::CoilW-1:0]  coils,
  input logic                         enable,
  input logic                         busy_res,
  input logic                         done_res
);

  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(coils) && $stable(enable)
      && $stable(busy_res) && $stable(done_res))
    else $error("result changed while stalled");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && done_res |-> !busy_res && !enable && coils == '0)
    else $error("done beat does not show an idle driver");

  a_enable_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> enable == busy_res)
    else $error("enable and busy disagree");

  a_idle_coils: assert property (@(posedge clk) disable iff (rst)
    res_valid && !busy_res |-> coils == '0)
    else $error("coils driven while idle");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result offered right after reset");

endmodule

bind stepper_half_step_sequencer_top hstep_checker u_hstep_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .coils     (res.coils),
  .enable    (res.enable),
  .busy_res  (res.busy_res),
  .done_res  (res.done_res)
);
